[design/ppt_pkg.sv]
// Shared constants for the pairwise preference tally.
// Field widths, command and status codes, stream packing, margin clamp and parameter defaults.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ppt_pkg;

    // Fixed field widths
    localparam int CAND_W       = 6;
    localparam int OUT_MARGIN_W = 16;
    localparam int PAIR_W       = 32;
    localparam int BCNT_W       = 16;

    // Stream packing
    localparam int IN_TDATA_W  = 24;   // candidate, row_cand, col_cand, zero pad
    localparam int OUT_TDATA_W = 64;   // margin, pair_total, ballot_count

    // Read-side clamp of a stored margin
    localparam int OUT_MARGIN_MAX = 32767;

    // Parameter defaults
    localparam int NUM_CANDS_DEF   = 64;
    localparam int MAX_BALLOT_DEF  = 64;
    localparam int MARGIN_BITS_DEF = 16;

    // Command carried on s_axis_tuser
    localparam logic CMD_ADD  = 1'b0;
    localparam logic CMD_READ = 1'b1;

    // Status carried on m_axis_tuser
    localparam logic STATUS_OK      = 1'b0;
    localparam logic STATUS_DROPPED = 1'b1;

endpackage : ppt_pkg

`default_nettype wire

[design/pairwise_preference_tally_top.sv]
// An add with earlier entries on its ballot walks them in order, doing two matrix
// read-modify-writes per earlier entry through the single matrix read port; a read
// fetches one matrix cell; a dropped entry or out-of-range read goes to the result.
// s_axis_tready stays low until the result is loaded into the output register, so a new
// item is taken only after the last one is through; m_axis_tready low holds it longer.
// Reset: asynchronous, active low; afterwards a clearing pass writes zero to all
// NUM_CANDS*NUM_CANDS matrix cells with s_axis_tready low.
`timescale 1ns / 1ps
`default_nettype none

module pairwise_preference_tally_top
    import ppt_pkg::*;
#(
    parameter int NUM_CANDS   = NUM_CANDS_DEF,
    parameter int MAX_BALLOT  = MAX_BALLOT_DEF,
    parameter int MARGIN_BITS = MARGIN_BITS_DEF
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,

    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    // [5:0] candidate, [11:6] row_cand, [17:12] col_cand, [23:18] zero
    input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
    input  wire logic                   s_axis_tuser,   // [0] cmd
    input  wire logic                   s_axis_tlast,   // ballot_end

    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    // [15:0] margin, [47:16] pair_total, [63:48] ballot_count
    output logic      [OUT_TDATA_W-1:0] m_axis_tdata,
    output logic                        m_axis_tuser    // [0] status
);

    localparam int MDEPTH = NUM_CANDS * NUM_CANDS;
    localparam int MA_W   = $clog2(MDEPTH);
    localparam int BA_W   = $clog2(MAX_BALLOT);

    logic                   buf_we;
    logic [BA_W-1:0]        buf_waddr;
    logic [CAND_W-1:0]      buf_wdata;
    logic [BA_W-1:0]        buf_raddr;
    logic [CAND_W-1:0]      buf_rdata;

    logic                   mat_we;
    logic [MA_W-1:0]        mat_waddr;
    logic [MARGIN_BITS-1:0] mat_wdata;
    logic [MA_W-1:0]        mat_raddr;
    logic [MARGIN_BITS-1:0] mat_rdata;

    ppt_ctrl #(
        .NUM_CANDS   (NUM_CANDS),
        .MAX_BALLOT  (MAX_BALLOT),
        .MARGIN_BITS (MARGIN_BITS)
    ) u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .buf_we        (buf_we),
        .buf_waddr     (buf_waddr),
        .buf_wdata     (buf_wdata),
        .buf_raddr     (buf_raddr),
        .buf_rdata     (buf_rdata),
        .mat_we        (mat_we),
        .mat_waddr     (mat_waddr),
        .mat_wdata     (mat_wdata),
        .mat_raddr     (mat_raddr),
        .mat_rdata     (mat_rdata)
    );

    ppt_ram #(
        .WIDTH (CAND_W),
        .DEPTH (MAX_BALLOT)
    ) u_ballot_buf (
        .clk   (clk),
        .we    (buf_we),
        .waddr (buf_waddr),
        .wdata (buf_wdata),
        .raddr (buf_raddr),
        .rdata (buf_rdata)
    );

    ppt_ram #(
        .WIDTH (MARGIN_BITS),
        .DEPTH (MDEPTH)
    ) u_margin_mat (
        .clk   (clk),
        .we    (mat_we),
        .waddr (mat_waddr),
        .wdata (mat_wdata),
        .raddr (mat_raddr),
        .rdata (mat_rdata)
    );

endmodule : pairwise_preference_tally_top

`default_nettype wire

[design/ppt_ram.sv]
// Generic simple dual-port RAM: one write port, one read port, registered read.
// A read of the address being written returns the old contents.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module ppt_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule : ppt_ram

`default_nettype wire

[design/ppt_sat.sv]
// Margin arithmetic: saturating +1 / -1 update of a stored margin, and the
// clamp of a stored margin to the 16-bit result range. Uses ppt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ppt_sat
    import ppt_pkg::*;
#(
    parameter int MARGIN_BITS = MARGIN_BITS_DEF
) (
    input  wire logic [MARGIN_BITS-1:0]  cur,
    input  wire logic                    inc,
    output logic      [MARGIN_BITS-1:0]  upd,
    output logic      [OUT_MARGIN_W-1:0] rd_margin
);

    localparam logic [MARGIN_BITS-1:0] M_MAX = {1'b0, {(MARGIN_BITS-1){1'b1}}};
    localparam logic [MARGIN_BITS-1:0] M_MIN = {1'b1, {(MARGIN_BITS-2){1'b0}}, 1'b1};
    localparam logic [OUT_MARGIN_W-1:0] O_MAX = OUT_MARGIN_W'(OUT_MARGIN_MAX);
    localparam logic [OUT_MARGIN_W-1:0] O_MIN = OUT_MARGIN_W'(-OUT_MARGIN_MAX);

    logic [32:0] cur_ext;

    // Symmetric saturation keeps the matrix antisymmetric
    always_comb
    begin
        if (inc)
        begin
            upd = (cur == M_MAX) ? cur : cur + MARGIN_BITS'(1);
        end
        else
        begin
            upd = (cur == M_MIN) ? cur : cur - MARGIN_BITS'(1);
        end
    end

    assign cur_ext = {{(33-MARGIN_BITS){cur[MARGIN_BITS-1]}}, cur};

    always_comb
    begin
        if ($signed(cur_ext) > 33'sd32767)
        begin
            rd_margin = O_MAX;
        end
        else if ($signed(cur_ext) < -33'sd32767)
        begin
            rd_margin = O_MIN;
        end
        else
        begin
            rd_margin = cur_ext[OUT_MARGIN_W-1:0];
        end
    end

endmodule : ppt_sat

`default_nettype wire

[design/ppt_ctrl.sv]
// Sequencer for the pairwise preference tally: clearing pass, ballot walk with
// matrix read-modify-write, margin reads, counters and output register.
// Uses ppt_pkg and ppt_sat; drives the ballot buffer and margin matrix RAMs.
`timescale 1ns / 1ps
`default_nettype none

module ppt_ctrl
    import ppt_pkg::*;
#(
    parameter int NUM_CANDS   = NUM_CANDS_DEF,
    parameter int MAX_BALLOT  = MAX_BALLOT_DEF,
    parameter int MARGIN_BITS = MARGIN_BITS_DEF,
    localparam int MA_W       = $clog2(NUM_CANDS * NUM_CANDS),
    localparam int BA_W       = $clog2(MAX_BALLOT)
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,

    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,   // candidate, row_cand, col_cand
    input  wire logic                   s_axis_tuser,   // cmd
    input  wire logic                   s_axis_tlast,   // ballot_end

    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    output logic      [OUT_TDATA_W-1:0] m_axis_tdata,   // margin, pair_total, ballot_count
    output logic                        m_axis_tuser,   // status

    output logic                        buf_we,
    output logic      [BA_W-1:0]        buf_waddr,
    output logic      [CAND_W-1:0]      buf_wdata,
    output logic      [BA_W-1:0]        buf_raddr,
    input  wire logic [CAND_W-1:0]      buf_rdata,

    output logic                        mat_we,
    output logic      [MA_W-1:0]        mat_waddr,
    output logic      [MARGIN_BITS-1:0] mat_wdata,
    output logic      [MA_W-1:0]        mat_raddr,
    input  wire logic [MARGIN_BITS-1:0] mat_rdata
);

    localparam int MDEPTH = NUM_CANDS * NUM_CANDS;
    localparam int BL_W   = $clog2(MAX_BALLOT + 1);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ADD_START,
        ST_RUN,
        ST_RD_ISSUE,
        ST_RD_WAIT,
        ST_DONE
    } state_t;

    state_t                    state_reg;
    logic [MA_W-1:0]           clr_addr_reg;
    logic [CAND_W-1:0]         cand_reg;
    logic [CAND_W-1:0]         row_reg;
    logic [CAND_W-1:0]         col_reg;
    logic [CAND_W-1:0]         prev_reg;
    logic                      end_reg;
    logic                      add_ok_reg;
    logic [BL_W-1:0]           len_reg;
    logic [BA_W-1:0]           k_reg;
    logic                      ph_reg;
    logic                      s1_valid_reg;
    logic [MA_W-1:0]           s1_addr_reg;
    logic                      s1_inc_reg;
    logic [PAIR_W-1:0]         pair_reg;
    logic [BCNT_W-1:0]         bcnt_reg;
    logic                      status_reg;
    logic [OUT_MARGIN_W-1:0]   margin_reg;
    logic                      out_valid_reg;
    logic                      out_status_reg;
    logic [OUT_TDATA_W-1:0]    out_data_reg;

    logic [CAND_W-1:0]         in_cand;
    logic [CAND_W-1:0]         in_row;
    logic [CAND_W-1:0]         in_col;
    logic [MARGIN_BITS-1:0]    upd_margin;
    logic [OUT_MARGIN_W-1:0]   rd_margin;
    logic [BCNT_W-1:0]         bcnt_next;
    logic                      out_free;
    logic                      accept;

    function automatic logic [MA_W-1:0] cell_addr(input logic [CAND_W-1:0] r,
                                                   input logic [CAND_W-1:0] c);
        return MA_W'(r) * MA_W'(NUM_CANDS) + MA_W'(c);
    endfunction

    assign in_cand = s_axis_tdata[CAND_W-1:0];
    assign in_row  = s_axis_tdata[2*CAND_W-1:CAND_W];
    assign in_col  = s_axis_tdata[3*CAND_W-1:2*CAND_W];

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign out_free      = !out_valid_reg || m_axis_tready;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_status_reg;

    assign bcnt_next = (end_reg && bcnt_reg != {BCNT_W{1'b1}}) ?
                       bcnt_reg + BCNT_W'(1) : bcnt_reg;

    ppt_sat #(
        .MARGIN_BITS (MARGIN_BITS)
    ) u_sat (
        .cur       (mat_rdata),
        .inc       (s1_inc_reg),
        .upd       (upd_margin),
        .rd_margin (rd_margin)
    );

    // Ballot buffer: append the new entry, walk earlier entries one ahead of use
    always_comb
    begin
        buf_we    = (state_reg == ST_ADD_START);
        buf_waddr = len_reg[BA_W-1:0];
        buf_wdata = cand_reg;
        if (state_reg == ST_RUN)
        begin
            buf_raddr = k_reg + BA_W'(1);
        end
        else
        begin
            buf_raddr = '0;
        end
    end

    // Margin matrix: walk and margin reads; clearing writes, walk write-back next cycle
    always_comb
    begin
        case (state_reg)
            ST_RUN:
            begin
                mat_raddr = ph_reg ? cell_addr(cand_reg, prev_reg)
                                   : cell_addr(buf_rdata, cand_reg);
            end
            ST_RD_ISSUE:
            begin
                mat_raddr = cell_addr(row_reg, col_reg);
            end
            default:
            begin
                mat_raddr = '0;
            end
        endcase

        if (state_reg == ST_CLEAR)
        begin
            mat_we    = 1'b1;
            mat_waddr = clr_addr_reg;
            mat_wdata = '0;
        end
        else
        begin
            mat_we    = s1_valid_reg;
            mat_waddr = s1_addr_reg;
            mat_wdata = upd_margin;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            clr_addr_reg   <= '0;
            cand_reg       <= '0;
            row_reg        <= '0;
            col_reg        <= '0;
            prev_reg       <= '0;
            end_reg        <= 1'b0;
            add_ok_reg     <= 1'b0;
            len_reg        <= '0;
            k_reg          <= '0;
            ph_reg         <= 1'b0;
            s1_valid_reg   <= 1'b0;
            s1_addr_reg    <= '0;
            s1_inc_reg     <= 1'b0;
            pair_reg       <= '0;
            bcnt_reg       <= '0;
            status_reg     <= STATUS_OK;
            margin_reg     <= '0;
            out_valid_reg  <= 1'b0;
            out_status_reg <= STATUS_OK;
            out_data_reg   <= '0;
        end
        else
        begin
            // Write-back is only issued by the walk
            if (state_reg != ST_RUN)
            begin
                s1_valid_reg <= 1'b0;
            end

            // Drop a taken result; the done state reloads it on its own
            if (out_valid_reg && m_axis_tready && state_reg != ST_DONE)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_CLEAR:
                begin
                    clr_addr_reg <= clr_addr_reg + MA_W'(1);
                    if (clr_addr_reg == MA_W'(MDEPTH - 1))
                    begin
                        state_reg <= ST_IDLE;
                    end
                end

                ST_IDLE:
                begin
                    if (accept)
                    begin
                        cand_reg   <= in_cand;
                        row_reg    <= in_row;
                        col_reg    <= in_col;
                        margin_reg <= '0;
                        if (s_axis_tuser == CMD_ADD)
                        begin
                            end_reg <= s_axis_tlast;
                            if (len_reg == BL_W'(MAX_BALLOT) ||
                                32'(in_cand) >= 32'(NUM_CANDS))
                            begin
                                status_reg <= STATUS_DROPPED;
                                add_ok_reg <= 1'b0;
                                state_reg  <= ST_DONE;
                            end
                            else
                            begin
                                status_reg <= STATUS_OK;
                                add_ok_reg <= 1'b1;
                                state_reg  <= ST_ADD_START;
                            end
                        end
                        else
                        begin
                            end_reg    <= 1'b0;
                            add_ok_reg <= 1'b0;
                            status_reg <= STATUS_OK;
                            if (32'(in_row) < 32'(NUM_CANDS) &&
                                32'(in_col) < 32'(NUM_CANDS))
                            begin
                                state_reg <= ST_RD_ISSUE;
                            end
                            else
                            begin
                                state_reg <= ST_DONE;
                            end
                        end
                    end
                end

                ST_ADD_START:
                begin
                    k_reg  <= '0;
                    ph_reg <= 1'b0;
                    state_reg <= (len_reg == '0) ? ST_DONE : ST_RUN;
                end

                ST_RUN:
                begin
                    if (!ph_reg)
                    begin
                        // Earlier entry gains one against the new candidate
                        prev_reg     <= buf_rdata;
                        s1_valid_reg <= (buf_rdata != cand_reg);
                        s1_addr_reg  <= cell_addr(buf_rdata, cand_reg);
                        s1_inc_reg   <= 1'b1;
                        ph_reg       <= 1'b1;
                    end
                    else
                    begin
                        // Mirrored cell loses one
                        s1_valid_reg <= (prev_reg != cand_reg);
                        s1_addr_reg  <= cell_addr(cand_reg, prev_reg);
                        s1_inc_reg   <= 1'b0;
                        ph_reg       <= 1'b0;
                        if (pair_reg != {PAIR_W{1'b1}})
                        begin
                            pair_reg <= pair_reg + PAIR_W'(1);
                        end
                        if ((BL_W'(k_reg) + BL_W'(1)) == len_reg)
                        begin
                            state_reg <= ST_DONE;
                        end
                        else
                        begin
                            k_reg <= k_reg + BA_W'(1);
                        end
                    end
                end

                ST_RD_ISSUE:
                begin
                    state_reg <= ST_RD_WAIT;
                end

                ST_RD_WAIT:
                begin
                    margin_reg <= rd_margin;
                    state_reg  <= ST_DONE;
                end

                ST_DONE:
                begin
                    // Hold until the output register can take the result
                    if (out_free)
                    begin
                        out_valid_reg  <= 1'b1;
                        out_status_reg <= status_reg;
                        out_data_reg   <= {bcnt_next, pair_reg, margin_reg};
                        bcnt_reg       <= bcnt_next;
                        if (end_reg)
                        begin
                            len_reg <= '0;
                        end
                        else if (add_ok_reg)
                        begin
                            len_reg <= len_reg + BL_W'(1);
                        end
                        state_reg <= ST_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule : ppt_ctrl

`default_nettype wire
